// File: hw/rtl/tplq_pkg.sv
// Shared types and constants for the three-level priority queue.
// Holds the entry layout, response codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
package tplq_pkg;

	localparam int CAT_W = 2;
	localparam int ID_W  = 16;
	localparam int DUR_W = 16;
	localparam int OCC_W = 8;
	localparam int RANK_W = 3;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// One above the least urgent rank, so the first scanned entry always wins.
	localparam logic [RANK_W-1:0] RANK_NONE = 3'd4;

	typedef struct packed {
		logic [CAT_W-1:0] cat;
		logic [ID_W-1:0]  id;
		logic [DUR_W-1:0] dur;
	} entry_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_SHIFT_INIT,
		S_SHIFT,
		S_POP_FIN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    capture;
		logic    push_wr;
		logic    rd;
		logic    scan_eval;
		logic    shift_init;
		logic    shift_wr;
		logic    dec;
		logic    res_load;
		status_t res_code;
	} cmd_t;

	typedef struct packed {
		logic is_pop;
		logic full;
		logic empty;
		logic idx_end;
		logic out_free;
	} sts_t;

	// Urgency rank: category 1 is most urgent, category 0 least.
	function automatic logic [RANK_W-1:0] rank_of(input logic [CAT_W-1:0] cat);
		logic [CAT_W-1:0] r;
		r = cat + 2'd3;
		return {1'b0, r};
	endfunction

endpackage

// File: hw/rtl/three_level_priority_queue.sv
// Three-level priority queue, top level: strict priority over four category ranks.
// Joins the controller and the datapath; depends on tplq_pkg.
//
// Requests are stored oldest first in a single-port-write, registered-read
// memory of DEPTH entries. A push is written in the dispatch state and
// answered from the response state. A pop reads every stored entry once to
// find the oldest request of the most urgent category, then reads and
// rewrites each later entry one place down, then decrements the count. One
// item is in work at a time; the result beat sits in an output register,
// so the next item can be accepted while it waits to be taken.
module three_level_priority_queue #(
	parameter int DEPTH = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  logic [tplq_pkg::CAT_W-1:0] req_category,
	input  logic [tplq_pkg::ID_W-1:0]  req_id,
	input  logic [tplq_pkg::DUR_W-1:0] req_duration,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [tplq_pkg::CAT_W-1:0] out_category,
	output logic [tplq_pkg::ID_W-1:0]  out_id,
	output logic [tplq_pkg::DUR_W-1:0] out_duration,
	output logic [tplq_pkg::OCC_W-1:0] occupancy
);
	import tplq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tplq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tplq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.req_category (req_category),
		.req_id       (req_id),
		.req_duration (req_duration),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_category (out_category),
		.out_id       (out_id),
		.out_duration (out_duration),
		.occupancy    (occupancy)
	);

endmodule

// File: hw/rtl/tplq_ctrl.sv
// Controller state machine of the three-level priority queue.
// Sequences push, scan, shift and response; depends on tplq_pkg.
module tplq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tplq_pkg::sts_t sts,
	output tplq_pkg::cmd_t cmd
);
	import tplq_pkg::*;

	state_t  state_q, state_d;
	status_t code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_DONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (sts.is_pop) begin
					code_d  = sts.empty ? ST_EMPTY : ST_DONE;
					state_d = sts.empty ? S_RESP : S_SCAN;
				end else begin
					code_d  = sts.full ? ST_FULL : ST_DONE;
					state_d = S_RESP;
				end
			end
			S_SCAN: begin
				if (sts.idx_end) state_d = S_SHIFT_INIT;
			end
			S_SHIFT_INIT: state_d = S_SHIFT;
			S_SHIFT: begin
				if (sts.idx_end) state_d = S_POP_FIN;
			end
			S_POP_FIN: state_d = S_RESP;
			S_RESP: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.res_code = code_q;
		in_stall     = (state_q != S_IDLE);
		case (state_q)
			S_IDLE:       cmd.capture = in_valid;
			S_DISPATCH:   cmd.push_wr = !sts.is_pop && !sts.full;
			S_SCAN: begin
				cmd.rd        = !sts.idx_end;
				cmd.scan_eval = 1'b1;
			end
			S_SHIFT_INIT: cmd.shift_init = 1'b1;
			S_SHIFT: begin
				cmd.rd       = !sts.idx_end;
				cmd.shift_wr = 1'b1;
			end
			S_POP_FIN:    cmd.dec = 1'b1;
			S_RESP:       cmd.res_load = sts.out_free;
			default:      cmd = '0;
		endcase
	end

endmodule

// File: hw/rtl/tplq_datapath.sv
// Datapath of the three-level priority queue: entry memory, count,
// scan index, best-entry tracking and the output register; depends on tplq_pkg.
module tplq_datapath #(
	parameter int DEPTH = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tplq_pkg::cmd_t                cmd,
	output tplq_pkg::sts_t                sts,
	input  logic                          func,
	input  logic [tplq_pkg::CAT_W-1:0]    req_category,
	input  logic [tplq_pkg::ID_W-1:0]     req_id,
	input  logic [tplq_pkg::DUR_W-1:0]    req_duration,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [tplq_pkg::CAT_W-1:0]    out_category,
	output logic [tplq_pkg::ID_W-1:0]     out_id,
	output logic [tplq_pkg::DUR_W-1:0]    out_duration,
	output logic [tplq_pkg::OCC_W-1:0]    occupancy
);
	import tplq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t mem [DEPTH];

	logic          func_q;
	entry_t        req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	entry_t        rd_data_q;
	logic          rv_q;
	logic [AW-1:0] ridx_q;
	logic [RANK_W-1:0] best_rank_q;
	logic [AW-1:0] best_idx_q;
	entry_t        best_q;
	logic          out_valid_q;
	logic          out_free;
	logic [RANK_W-1:0] rd_rank;

	assign out_free = !out_valid_q || !out_stall;
	assign rd_rank  = rank_of(rd_data_q.cat);

	assign sts.is_pop   = (func_q == FUNC_POP);
	assign sts.full     = (count_q == CW'(DEPTH));
	assign sts.empty    = (count_q == '0);
	assign sts.idx_end  = (idx_q == count_q);
	assign sts.out_free = out_free;

	// Memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.push_wr) begin
			mem[count_q[AW-1:0]] <= req_q;
		end else if (cmd.shift_wr && rv_q) begin
			mem[ridx_q - AW'(1)] <= rd_data_q;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= func;
			req_q   <= '{cat: req_category, id: req_id, dur: req_duration};
		end
		if (cmd.rd) ridx_q <= idx_q[AW-1:0];
		if (cmd.capture) begin
			best_rank_q <= RANK_NONE;
		end else if (cmd.scan_eval && rv_q && (rd_rank < best_rank_q)) begin
			// Strict compare keeps the oldest entry among equal ranks.
			best_rank_q <= rd_rank;
			best_idx_q  <= ridx_q;
			best_q      <= rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			rv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rv_q <= cmd.rd;
			if (cmd.push_wr) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.shift_init) begin
				idx_q <= CW'(best_idx_q) + CW'(1);
			end else if (cmd.rd) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status    <= cmd.res_code;
			occupancy <= OCC_W'(count_q);
			if ((cmd.res_code == ST_DONE) && (func_q == FUNC_POP)) begin
				out_category <= best_q.cat;
				out_id       <= best_q.id;
				out_duration <= best_q.dur;
			end else begin
				out_category <= '0;
				out_id       <= '0;
				out_duration <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
